// ----- sv/rcd_pkg.sv -----
// Package for the restricted circular deque: widths, operation and status codes,
// and the command and status structs passed between controller and datapath.
// No dependencies.
package rcd_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int DATA_W    = 32;
	localparam int MODE_W    = 3;
	localparam int STAT_W    = 2;

	// Operation codes carried on s_tuser
	localparam logic [MODE_W-1:0] MODE_INS_R = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_L = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DEL_L = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DEL_R = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LIST  = 3'd4;

	// Result status codes carried on m_tuser
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVER   = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDER  = 2'd2;
	localparam logic [STAT_W-1:0] ST_DENIED = 2'd3;

	// Restriction register values
	localparam logic RESTR_IN  = 1'b0;
	localparam logic RESTR_OUT = 1'b1;

	// Store read address select
	localparam logic [1:0] RD_LEFT  = 2'd0;
	localparam logic [1:0] RD_RIGHT = 2'd1;
	localparam logic [1:0] RD_POS   = 2'd2;

	typedef struct packed {
		logic              load_in;     // capture the accepted beat
		logic              ins;         // insert value_q, move a pointer
		logic              del;         // remove one word, move a pointer
		logic              rd_en;       // read the store
		logic [1:0]        rd_sel;      // read address select
		logic              list_start;  // walk pointer to left slot
		logic              list_next;   // advance walk pointer
		logic              out_load;    // load the output register
		logic              out_ram;     // output data from store, else zero
		logic [STAT_W-1:0] out_status;
		logic              out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              restr;
		logic              empty;
		logic              full;
		logic              pos_at_right;
	} dp_stat_t;

endpackage

// ----- sv/restricted_circular_deque_top.sv -----
// Restricted circular deque: a deque of 32-bit words in a circular store of
// DEPTH words, with a one-bit register choosing input- or output-restricted mode.
//
// Input beat (s_*): s_tuser carries the operation (insert right, insert left,
// delete left, delete right, list), s_tdata the word to insert.
// Output beat (m_*): m_tdata the removed or listed word (zero otherwise),
// m_tuser the status (ok, overflow, underflow/empty, not allowed), m_tlast
// marks the final beat caused by one input beat.
// Config (cfg_*): cfg_data[0] writes the restriction; cfg_ready is always high.
// Write it only while no operation is in flight.
// A status-only result is loaded in the execute step that follows acceptance;
// a delete reads the store there and loads the word in its delete step (store
// read is registered). A listing holds s_tready low and gives each word by a
// store read followed by the output load, taking no new beat until the last
// word is loaded.
// One beat is taken while the previous result still sits in the output
// register; a stalled m_tready then holds the block in its output-loading step.
// Reset leaves the deque empty and the restriction at input-restricted; the
// store contents stay undefined until written.
module restricted_circular_deque_top #(
	parameter int DEPTH = rcd_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rcd_pkg::DATA_W-1:0]   s_tdata,   // [31:0] value
	input  logic [rcd_pkg::MODE_W-1:0]   s_tuser,   // [2:0] mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rcd_pkg::DATA_W-1:0]   m_tdata,   // [31:0] data
	output logic [rcd_pkg::STAT_W-1:0]   m_tuser,   // [1:0] status
	output logic                         m_tlast,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [0:0]                   cfg_data   // [0] restriction
);
	import rcd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	rcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rcd_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_value   (s_tdata),
		.in_mode    (s_tuser),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_bit    (cfg_data[0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_data   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

`ifndef SYNTHESIS
	// Never write into a full deque
	a_no_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> !stat.full)
		else $error("insert issued while full");

	// Never remove from an empty deque
	a_no_del_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |-> !stat.empty)
		else $error("delete issued while empty");

	// Any non-ok result closes its operation
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> m_tlast)
		else $error("error status without last");

	// One operation at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("back-to-back accept");
`endif

endmodule

// ----- sv/rcd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on rcd_pkg for default widths.
module rcd_ram #(
	parameter int WIDTH = rcd_pkg::DATA_W,
	parameter int DEPTH = rcd_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/rcd_dp.sv -----
// Datapath of the restricted circular deque: pointers, empty flag, restriction
// register, walk pointer, store RAM and output payload. Depends on rcd_pkg, rcd_ram.
module rcd_dp #(
	parameter int DEPTH = rcd_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rcd_pkg::DATA_W-1:0]   in_value,
	input  logic [rcd_pkg::MODE_W-1:0]   in_mode,
	input  logic                         cfg_we,
	input  logic                         cfg_bit,
	input  rcd_pkg::dp_cmd_t             cmd,
	output rcd_pkg::dp_stat_t            stat,
	output logic [rcd_pkg::DATA_W-1:0]   out_data,
	output logic [rcd_pkg::STAT_W-1:0]   out_status,
	output logic                         out_last
);
	import rcd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] TOP_SLOT = AW'(DEPTH - 1);

	logic [AW-1:0]     left_q, right_q, pos_q;
	logic              empty_q, restr_q;
	logic [MODE_W-1:0] mode_q;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] data_q;
	logic [STAT_W-1:0] status_q;
	logic              last_q;

	logic [AW-1:0]     nxt_right, prv_right, nxt_left, prv_left, nxt_pos;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [DATA_W-1:0] rd_data;

	function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
		slot_next = (s == TOP_SLOT) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
		slot_prev = (s == '0) ? TOP_SLOT : s - 1'b1;
	endfunction

	assign nxt_right = slot_next(right_q);
	assign prv_right = slot_prev(right_q);
	assign nxt_left  = slot_next(left_q);
	assign prv_left  = slot_prev(left_q);
	assign nxt_pos   = slot_next(pos_q);

	// Status toward the controller
	always_comb begin
		stat.mode         = mode_q;
		stat.restr        = restr_q;
		stat.empty        = empty_q;
		stat.full         = !empty_q && (nxt_right == left_q);
		stat.pos_at_right = (pos_q == right_q);
	end

	// Capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q  <= in_mode;
			value_q <= in_value;
		end
	end

	// Restriction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restr_q <= RESTR_IN;
		end else if (cfg_we) begin
			restr_q <= cfg_bit;
		end
	end

	// Pointers and empty flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
			empty_q <= 1'b1;
		end else if (cmd.ins) begin
			if (empty_q) begin
				left_q  <= '0;
				right_q <= '0;
				empty_q <= 1'b0;
			end else if (mode_q == MODE_INS_R) begin
				right_q <= nxt_right;
			end else begin
				left_q <= prv_left;
			end
		end else if (cmd.del) begin
			if (left_q == right_q) begin
				left_q  <= '0;
				right_q <= '0;
				empty_q <= 1'b1;
			end else if (mode_q == MODE_DEL_L) begin
				left_q <= nxt_left;
			end else begin
				right_q <= prv_right;
			end
		end
	end

	// Walk pointer for listing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.list_start) begin
			pos_q <= left_q;
		end else if (cmd.list_next) begin
			pos_q <= nxt_pos;
		end
	end

	// Store addresses
	always_comb begin
		if (empty_q) begin
			wr_addr = '0;
		end else if (mode_q == MODE_INS_R) begin
			wr_addr = nxt_right;
		end else begin
			wr_addr = prv_left;
		end
		case (cmd.rd_sel)
			RD_LEFT:  rd_addr = left_q;
			RD_RIGHT: rd_addr = right_q;
			default:  rd_addr = pos_q;
		endcase
	end

	rcd_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.ins),
		.waddr (wr_addr),
		.wdata (value_q),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			data_q   <= cmd.out_ram ? rd_data : '0;
			status_q <= cmd.out_status;
			last_q   <= cmd.out_last;
		end
	end

	assign out_data   = data_q;
	assign out_status = status_q;
	assign out_last   = last_q;

endmodule

// ----- sv/rcd_ctrl.sv -----
// Controller of the restricted circular deque: sequences accept, execute,
// store reads and the listing walk, and owns the output valid. Depends on rcd_pkg.
module rcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rcd_pkg::dp_stat_t  stat,
	output rcd_pkg::dp_cmd_t   cmd
);
	import rcd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DEL  = 3'd2;
	localparam logic [2:0] S_LRD  = 3'd3;
	localparam logic [2:0] S_LOUT = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.out_status = ST_OK;
		cmd.rd_sel     = RD_POS;
		in_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.mode)
					MODE_INS_R, MODE_INS_L: begin
						if (out_free) begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							state_d      = S_IDLE;
							if (stat.mode == MODE_INS_L && stat.restr == RESTR_IN) begin
								cmd.out_status = ST_DENIED;
							end else if (stat.full) begin
								cmd.out_status = ST_OVER;
							end else begin
								cmd.ins = 1'b1;
							end
						end
					end
					MODE_DEL_L, MODE_DEL_R: begin
						if (stat.mode == MODE_DEL_R && stat.restr == RESTR_OUT) begin
							if (out_free) begin
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = ST_DENIED;
								state_d        = S_IDLE;
							end
						end else if (stat.empty) begin
							if (out_free) begin
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = ST_UNDER;
								state_d        = S_IDLE;
							end
						end else begin
							// read the end slot, then move the pointer
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = (stat.mode == MODE_DEL_L) ? RD_LEFT : RD_RIGHT;
							cmd.del    = 1'b1;
							state_d    = S_DEL;
						end
					end
					MODE_LIST: begin
						if (stat.empty) begin
							if (out_free) begin
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = ST_UNDER;
								state_d        = S_IDLE;
							end
						end else begin
							cmd.list_start = 1'b1;
							state_d        = S_LRD;
						end
					end
					default: begin
						if (out_free) begin
							cmd.out_load   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = ST_DENIED;
							state_d        = S_IDLE;
						end
					end
				endcase
			end
			S_DEL: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_ram  = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_LRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_POS;
				state_d    = S_LOUT;
			end
			S_LOUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_ram  = 1'b1;
					cmd.out_last = stat.pos_at_right;
					if (stat.pos_at_right) begin
						state_d = S_IDLE;
					end else begin
						cmd.list_next = 1'b1;
						state_d       = S_LRD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid: set on load, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
